@@ rtl/core/union_find_min_root_defines.svh @@
// Assertion macros for the union-find engine.
// Used by union_find_min_root.sv; depends on nothing else.
`ifndef UNION_FIND_MIN_ROOT_DEFINES_SVH
`define UNION_FIND_MIN_ROOT_DEFINES_SVH

`ifndef SYNTHESIS
// check that a property holds at every rising clock edge outside reset
`define UFMR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that a condition never occurs outside reset
`define UFMR_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define UFMR_ASSERT(name, clk, rst, prop, msg)
`define UFMR_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

@@ rtl/core/ufmr_pkg.sv @@
// Shared types and constants of the union-find engine.
// No dependencies; used by union_find_min_root.sv.
package ufmr_pkg;

   localparam int NODE_W     = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam logic KIND_FIND  = 1'b0;
   localparam logic KIND_UNION = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_COMP,
      ST_START_B,
      ST_LINK,
      ST_DONE
   } ufmr_state_type;

endpackage

@@ rtl/core/union_find_min_root.sv @@
// Union-find engine with full path compression over a parent table in RAM.
// Depends on ufmr_pkg, ufmr_ram and union_find_min_root_defines.svh.
//
// Usage:
//   Request channel (req_*): tdata carries node_a and node_b, tuser the kind
//   (find or union). Response channel (rsp_*): tdata carries the root of
//   node_a after the operation and a merged flag.
//   One request is worked at a time. A single RAM port pair serves every
//   step: the walk to the root reads one parent per cycle, and the
//   compression pass reads the next parent while rewriting the current one.
//   A find walks to the root and then rewrites each node on the path; a
//   node that is its own root skips the rewrite, and one out of range skips
//   the walk as well. A union of two in-range nodes adds a second find, for
//   node_b, and a link write on a merge. Compressed trees stay shallow.
//   After reset the block sweeps the table to identity, one entry per cycle,
//   with req_tready low. A result waits in the output register while the
//   receiver stalls; the next request is still taken, and its result is held
//   back until the register frees.
`include "union_find_min_root_defines.svh"

module union_find_min_root #(
   parameter int NODES = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [8:0] node_a, [17:9] node_b, [23:18] zero
   input  logic [ufmr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] kind
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [8:0] root, [9] merged, [15:10] zero
   output logic [ufmr_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int          NodeW     = ufmr_pkg::NODE_W;
   localparam int          AddrW     = $clog2(NODES);
   localparam logic [31:0] NodeLimit = 32'(NODES);

   ufmr_pkg::ufmr_state_type state_ff, state_in;

   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NodeW-1:0] cur_ff, cur_in;
   logic [NodeW-1:0] target_ff, target_in;
   logic [NodeW-1:0] root_ff, root_in;
   logic [NodeW-1:0] root_a_ff, root_a_in;
   logic [NodeW-1:0] node_b_ff, node_b_in;
   logic             union_ff, union_in;
   logic             second_ff, second_in;
   logic [NodeW-1:0] res_root_ff, res_root_in;
   logic             res_merged_ff, res_merged_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [NodeW-1:0] rsp_root_ff, rsp_root_in;
   logic             rsp_merged_ff, rsp_merged_in;

   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [NodeW-1:0] wr_data;
   logic             rd_en;
   logic [AddrW-1:0] rd_addr;
   logic [NodeW-1:0] rd_data;

   logic [NodeW-1:0] req_a;
   logic [NodeW-1:0] req_b;
   logic             a_in_range;
   logic             b_in_range;
   logic             fin_hit;
   logic [NodeW-1:0] fin_root;
   logic [NodeW-1:0] link_hi;
   logic [NodeW-1:0] link_lo;

   assign req_a      = req_tdata[NodeW-1:0];
   assign req_b      = req_tdata[2*NodeW-1:NodeW];
   assign a_in_range = (32'(req_a) < NodeLimit);
   assign b_in_range = (32'(req_b) < NodeLimit);
   assign link_hi    = (root_a_ff > root_ff) ? root_a_ff : root_ff;
   assign link_lo    = (root_a_ff > root_ff) ? root_ff : root_a_ff;

   ufmr_ram #(
      .WIDTH(NodeW),
      .DEPTH(NODES)
   ) u_parent_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ufmr_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
         union_ff      <= 1'b0;
         second_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         union_ff      <= union_in;
         second_ff     <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      target_ff     <= target_in;
      root_ff       <= root_in;
      root_a_ff     <= root_a_in;
      node_b_ff     <= node_b_in;
      res_root_ff   <= res_root_in;
      res_merged_ff <= res_merged_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      cur_in        = cur_ff;
      target_in     = target_ff;
      root_in       = root_ff;
      root_a_in     = root_a_ff;
      node_b_in     = node_b_ff;
      union_in      = union_ff;
      second_in     = second_ff;
      res_root_in   = res_root_ff;
      res_merged_in = res_merged_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_root_in   = rsp_root_ff;
      rsp_merged_in = rsp_merged_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = AddrW'(cur_ff);
      wr_data       = root_ff;
      rd_en         = 1'b0;
      rd_addr       = AddrW'(cur_ff);
      fin_hit       = 1'b0;
      fin_root      = cur_ff;

      unique case (state_ff)
         ufmr_pkg::ST_CLEAR: begin
            // write identity, one entry per cycle
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = NodeW'(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AddrW'(NODES - 1)) begin
               state_in = ufmr_pkg::ST_IDLE;
            end
         end
         ufmr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cur_in    = req_a;
               target_in = req_a;
               node_b_in = req_b;
               union_in  = (req_tuser[0] == ufmr_pkg::KIND_UNION) && a_in_range && b_in_range;
               second_in = 1'b0;
               if (a_in_range) begin
                  rd_en    = 1'b1;
                  rd_addr  = AddrW'(req_a);
                  state_in = ufmr_pkg::ST_WALK;
               end else begin
                  // out-of-range node is its own lone root
                  res_root_in   = req_a;
                  res_merged_in = 1'b0;
                  state_in      = ufmr_pkg::ST_DONE;
               end
            end
         end
         ufmr_pkg::ST_WALK: begin
            if (rd_data == cur_ff) begin
               if (target_ff == cur_ff) begin
                  fin_hit  = 1'b1;
                  fin_root = cur_ff;
               end else begin
                  // root found; restart from the start node to compress
                  root_in  = cur_ff;
                  cur_in   = target_ff;
                  rd_en    = 1'b1;
                  rd_addr  = AddrW'(target_ff);
                  state_in = ufmr_pkg::ST_COMP;
               end
            end else begin
               cur_in  = rd_data;
               rd_en   = 1'b1;
               rd_addr = AddrW'(rd_data);
            end
         end
         ufmr_pkg::ST_COMP: begin
            // point current node at the root, fetch its old parent
            wr_en   = 1'b1;
            wr_addr = AddrW'(cur_ff);
            wr_data = root_ff;
            if (rd_data == root_ff) begin
               fin_hit  = 1'b1;
               fin_root = root_ff;
            end else begin
               cur_in  = rd_data;
               rd_en   = 1'b1;
               rd_addr = AddrW'(rd_data);
            end
         end
         ufmr_pkg::ST_START_B: begin
            rd_en    = 1'b1;
            rd_addr  = AddrW'(cur_ff);
            state_in = ufmr_pkg::ST_WALK;
         end
         ufmr_pkg::ST_LINK: begin
            // hang the larger root under the smaller one
            wr_en         = 1'b1;
            wr_addr       = AddrW'(link_hi);
            wr_data       = link_lo;
            res_root_in   = link_lo;
            res_merged_in = 1'b1;
            state_in      = ufmr_pkg::ST_DONE;
         end
         ufmr_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_root_in   = res_root_ff;
               rsp_merged_in = res_merged_ff;
               state_in      = ufmr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ufmr_pkg::ST_CLEAR;
         end
      endcase

      if (fin_hit) begin
         root_in = fin_root;
         if (!second_ff) begin
            root_a_in = fin_root;
            if (union_ff) begin
               second_in = 1'b1;
               cur_in    = node_b_ff;
               target_in = node_b_ff;
               state_in  = ufmr_pkg::ST_START_B;
            end else begin
               res_root_in   = fin_root;
               res_merged_in = 1'b0;
               state_in      = ufmr_pkg::ST_DONE;
            end
         end else if (root_a_ff == fin_root) begin
            res_root_in   = fin_root;
            res_merged_in = 1'b0;
            state_in      = ufmr_pkg::ST_DONE;
         end else begin
            state_in = ufmr_pkg::ST_LINK;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(ufmr_pkg::RSP_DATA_W - NodeW - 1){1'b0}}, rsp_merged_ff, rsp_root_ff};

   `UFMR_ASSERT(a_parent_not_above, clock, reset,
      (state_ff == ufmr_pkg::ST_WALK || state_ff == ufmr_pkg::ST_COMP) |-> (rd_data <= cur_ff),
      "parent larger than its node")
   `UFMR_ASSERT_NEVER(a_no_rw_collision, clock, reset,
      wr_en && rd_en && (wr_addr == rd_addr), "read and write to one entry in one cycle")
   `UFMR_ASSERT(a_link_down, clock, reset,
      (state_ff == ufmr_pkg::ST_LINK) |-> (root_a_ff != root_ff),
      "link of a root under itself")
   `UFMR_ASSERT(a_busy_after_accept, clock, reset,
      (req_tvalid && req_tready) |=> (state_ff != ufmr_pkg::ST_IDLE),
      "request accepted without leaving idle")

endmodule

@@ rtl/core/ufmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufmr_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/union_find_min_root_tb.sv @@
// Self-checking testbench for union_find_min_root: directed table, then random
// find/union traffic checked against a parent-table predictor kept in the bench.
// Depends on ufmr_pkg and the union_find_min_root RTL.
module union_find_min_root_tb;

   localparam int   NODE_W     = ufmr_pkg::NODE_W;
   localparam int   REQ_DATA_W = ufmr_pkg::REQ_DATA_W;
   localparam int   RSP_DATA_W = ufmr_pkg::RSP_DATA_W;
   localparam logic KIND_FIND  = ufmr_pkg::KIND_FIND;
   localparam logic KIND_UNION = ufmr_pkg::KIND_UNION;

   localparam int NODES          = 512;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 12000;
   localparam int END_SETTLE     = 64;

   typedef struct packed {
      logic [NODE_W-1:0] root;
      logic              merged;
   } uf_result_type;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic              typed;
      logic [NODE_W-1:0] root;
      logic              merged;
   } dir_row_type;

   typedef enum {
      RDY_ALWAYS,
      RDY_MOSTLY,
      RDY_SELDOM,
      RDY_PERIODIC
   } ready_mode_type;

   // typed root/merged only where obvious; typed = 0 rows are checked against the predictor
   localparam int DIR_ROWS = 21;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{KIND_FIND,  9'd0,   9'd0,   1'b1, 9'd0,   1'b0},
      '{KIND_FIND,  9'd511, 9'd0,   1'b1, 9'd511, 1'b0},
      '{KIND_UNION, 9'd0,   9'd511, 1'b1, 9'd0,   1'b1},
      '{KIND_UNION, 9'd511, 9'd0,   1'b1, 9'd0,   1'b0},
      '{KIND_UNION, 9'd7,   9'd7,   1'b1, 9'd7,   1'b0},
      '{KIND_FIND,  9'd511, 9'd511, 1'b1, 9'd0,   1'b0},
      '{KIND_UNION, 9'd510, 9'd509, 1'b1, 9'd509, 1'b1},
      '{KIND_UNION, 9'd509, 9'd508, 1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd508, 9'd507, 1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd507, 9'd506, 1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd506, 9'd505, 1'b0, 9'd0,   1'b0},
      '{KIND_FIND,  9'd510, 9'd0,   1'b0, 9'd0,   1'b0},
      '{KIND_FIND,  9'd510, 9'd0,   1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd505, 9'd7,   1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd511, 9'd510, 1'b0, 9'd0,   1'b0},
      '{KIND_FIND,  9'd509, 9'd0,   1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd341, 9'd170, 1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd170, 9'd341, 1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd256, 9'd255, 1'b0, 9'd0,   1'b0},
      '{KIND_UNION, 9'd255, 9'd170, 1'b0, 9'd0,   1'b0},
      '{KIND_FIND,  9'd256, 9'd511, 1'b0, 9'd0,   1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [8:0] node_a, [17:9] node_b, [23:18] zero
   logic [REQ_DATA_W-1:0] req_tdata;
   // [0] kind
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [8:0] root, [9] merged, [15:10] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [NODE_W-1:0] parent_copy [NODES];
   uf_result_type     pending_results [$];
   int                mismatch_count = 0;
   int                burst_left = 0;
   int                idle_cycles = 0;
   bit                long_hold_pending = 1'b0;

   always #6 clock = ~clock;

   union_find_min_root #(
      .NODES(NODES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   // walk to the root, then point every node on the path straight at it
   function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] node);
      int unsigned rt;
      int unsigned cur;
      int unsigned nxt;
      int unsigned p;
      int unsigned steps;
      if (node >= NODES) return node;
      rt = node;
      steps = 0;
      while (steps < NODES) begin
         p = parent_copy[rt];
         if (p == rt || p >= NODES) break;
         rt = p;
         steps++;
      end
      cur = node;
      steps = 0;
      while (cur != rt && steps < NODES) begin
         nxt = parent_copy[cur];
         parent_copy[cur] = rt[NODE_W-1:0];
         if (nxt >= NODES) break;
         cur = nxt;
         steps++;
      end
      return rt[NODE_W-1:0];
   endfunction

   function automatic uf_result_type predict_request(input logic kind,
                                                     input logic [NODE_W-1:0] a,
                                                     input logic [NODE_W-1:0] b);
      uf_result_type r;
      logic [NODE_W-1:0] ra;
      logic [NODE_W-1:0] rb;
      r.merged = 1'b0;
      if (kind == KIND_FIND || a >= NODES || b >= NODES) begin
         r.root = root_of(a);
      end else begin
         ra = root_of(a);
         rb = root_of(b);
         // link the larger root under the smaller one
         if (ra < rb) begin
            parent_copy[rb] = ra;
            r.root = ra;
            r.merged = 1'b1;
         end else if (rb < ra) begin
            parent_copy[ra] = rb;
            r.root = rb;
            r.merged = 1'b1;
         end else begin
            r.root = ra;
         end
      end
      return r;
   endfunction

   function automatic logic [NODE_W-1:0] pick_node(input int base);
      if ($urandom_range(0, 6) == 0) return NODE_W'($urandom_range(0, NODES - 1));
      return NODE_W'(base + $urandom_range(0, 63));
   endfunction

   task automatic issue_request(input logic kind, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b, input logic typed,
                                input logic [NODE_W-1:0] t_root, input logic t_merged);
      uf_result_type want;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 2 * NODE_W){1'b0}}, b, a};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      want = predict_request(kind, a, b);
      if (typed) begin
         want.root   = t_root;
         want.merged = t_merged;
      end
      pending_results.push_back(want);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off until every outstanding request has answered
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // request side
   initial begin
      int issued;
      int base;
      int len;
      int top;
      bit hold_done;
      bit drain_done;
      logic kind;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      for (int i = 0; i < NODES; i++) parent_copy[i] = NODE_W'(i);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         issue_request(DIRECTED[i].kind, DIRECTED[i].node_a, DIRECTED[i].node_b,
                       DIRECTED[i].typed, DIRECTED[i].root, DIRECTED[i].merged);
      end
      drain_responses();

      issued = 0;
      hold_done = 1'b0;
      drain_done = 1'b0;
      while (issued < RANDOM_ITEMS) begin
         base = 64 * $urandom_range(0, 7);
         if (!hold_done && issued >= 400) begin
            long_hold_pending = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && issued >= 800) begin
            drain_responses();
            drain_done = 1'b1;
         end
         if ($urandom_range(0, 2) == 0) begin
            // descending unions build a deep chain, then a find compresses it
            len = $urandom_range(3, 40);
            top = base + $urandom_range(len, 63);
            for (int k = 0; k < len; k++) begin
               issue_request(KIND_UNION, NODE_W'(top - k), NODE_W'(top - k - 1),
                             1'b0, '0, 1'b0);
               issued++;
            end
            issue_request(KIND_FIND, NODE_W'(top), pick_node(base), 1'b0, '0, 1'b0);
            issued++;
         end else begin
            len = $urandom_range(20, 80);
            for (int k = 0; k < len; k++) begin
               kind = ($urandom_range(0, 1) == 0) ? KIND_FIND : KIND_UNION;
               a = pick_node(base);
               b = ($urandom_range(0, 19) == 0) ? a : pick_node(base);
               issue_request(kind, a, b, 1'b0, '0, 1'b0);
               issued++;
            end
         end
      end

      drain_responses();
      repeat (END_SETTLE) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
      if (mismatch_count == 0) begin
         $display("union_find_min_root test passed");
      end else begin
         $display("union_find_min_root test failed");
      end
      $finish;
   end

   // response side: ready follows modes of its own, plus one long hold-off
   initial begin
      ready_mode_type mode;
      int mode_left;
      int phase;
      rsp_tready <= 1'b0;
      mode = RDY_ALWAYS;
      mode_left = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         phase++;
         case (mode)
            RDY_ALWAYS:   rsp_tready <= 1'b1;
            RDY_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
            RDY_SELDOM:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ((phase % 5) < 3);
         endcase
      end
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      uf_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending: root %0d merged %0d",
                                      rsp_tdata[NODE_W-1:0], rsp_tdata[NODE_W]));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[NODE_W-1:0] !== want.root)
               report_mismatch($sformatf("root got %0d expected %0d",
                                         rsp_tdata[NODE_W-1:0], want.root));
            if (rsp_tdata[NODE_W] !== want.merged)
               report_mismatch($sformatf("merged got %0d expected %0d",
                                         rsp_tdata[NODE_W], want.merged));
         end
      end
   end

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no request or response moved for %0d cycles", idle_cycles);
         $display("union_find_min_root test failed");
         $finish;
      end
   end

endmodule
